/* rtl/escape_marker_rle_decoder_top_macros.svh */
// Assertion helpers for the escape-marker RLE decoder.
`ifndef ESCAPE_MARKER_RLE_DECODER_TOP_MACROS_SVH
`define ESCAPE_MARKER_RLE_DECODER_TOP_MACROS_SVH

// Check a property on every rising edge of aclk outside reset.
`define EMRLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check an implication that must hold in the same cycle.
`define EMRLE_ASSERT_IMPL(label, cond, cons, msg) \
    `EMRLE_ASSERT(label, (cond) |-> (cons), msg)

`endif

/* rtl/emrle_pkg.sv */
`default_nettype none
package emrle_pkg;

    // Escape marker bytes, in stream order
    localparam logic [7:0] MARK_A = 8'hCB;
    localparam logic [7:0] MARK_B = 8'hED;
    localparam logic [7:0] MARK_C = 8'h37;

    // Most results one input byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    // Escape phase of the front end
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FILL   = 2'd1,
        PH_CNT_HI = 2'd2,
        PH_CNT_LO = 2'd3
    } phase_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [1:0]                    count;
        logic                          err;
        logic                          eos;
        logic [MAX_RESULTS-1:0][7:0]   value;
        logic [MAX_RESULTS-1:0][15:0]  length;
    } bundle_t;

endpackage
`default_nettype wire

/* rtl/emrle_front.sv */
`default_nettype none
module emrle_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_eos,
    output logic                   push,
    output emrle_pkg::bundle_t     bundle
);
    import emrle_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  lc_reg, lc_next;
    logic [7:0]  lb0_reg, lb0_next;
    logic [7:0]  lb1_reg, lb1_next;
    logic [7:0]  fill_reg, fill_next;
    logic [7:0]  ch_reg, ch_next;
    logic        marker;
    logic        err;

    // Full marker seen: two pending bytes plus the incoming one
    assign marker = lc_reg[1] && (lb0_reg == MARK_A) && (lb1_reg == MARK_B)
                    && (in_byte == MARK_C);

    // Next escape phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:   if (marker) phase_next = PH_FILL;
            PH_FILL:   phase_next = PH_CNT_HI;
            PH_CNT_HI: phase_next = PH_CNT_LO;
            PH_CNT_LO: phase_next = PH_IDLE;
            default:   phase_next = PH_IDLE;
        endcase
        if (in_eos) phase_next = PH_IDLE;
    end

    // Results and window update for the incoming byte
    always_comb begin
        lb0_next  = lb0_reg;
        lb1_next  = lb1_reg;
        lc_next   = lc_reg;
        fill_next = fill_reg;
        ch_next   = ch_reg;
        err       = 1'b0;
        bundle    = '0;
        bundle.eos = in_eos;
        unique case (phase_reg)
            PH_FILL: begin
                fill_next = in_byte;
                err       = in_eos;
            end
            PH_CNT_HI: begin
                ch_next = in_byte;
                err     = in_eos;
            end
            PH_CNT_LO: begin
                if ({ch_reg, in_byte} != 16'd0) begin
                    bundle.value[0]  = fill_reg;
                    bundle.length[0] = {ch_reg, in_byte};
                    bundle.count     = 2'd1;
                end
            end
            default: begin
                if (marker) begin
                    lc_next = 2'd0;
                    err     = in_eos;
                end else if (lc_reg[1]) begin
                    // Oldest byte leaves as a literal, window shifts
                    bundle.value[0]  = lb0_reg;
                    bundle.length[0] = 16'd1;
                    bundle.count     = 2'd1;
                    lb0_next = lb1_reg;
                    lb1_next = in_byte;
                    if (in_eos) begin
                        bundle.value[1]  = lb1_reg;
                        bundle.length[1] = 16'd1;
                        bundle.value[2]  = in_byte;
                        bundle.length[2] = 16'd1;
                        bundle.count     = 2'd3;
                    end
                end else if (lc_reg[0]) begin
                    lb1_next = in_byte;
                    lc_next  = 2'd2;
                    if (in_eos) begin
                        bundle.value[0]  = lb0_reg;
                        bundle.length[0] = 16'd1;
                        bundle.value[1]  = in_byte;
                        bundle.length[1] = 16'd1;
                        bundle.count     = 2'd2;
                    end
                end else begin
                    lb0_next = in_byte;
                    lc_next  = 2'd1;
                    if (in_eos) begin
                        bundle.value[0]  = in_byte;
                        bundle.length[0] = 16'd1;
                        bundle.count     = 2'd1;
                    end
                end
            end
        endcase
        // End of stream: truncation error or empty end marker
        if (in_eos) begin
            if (err) begin
                bundle       = '0;
                bundle.eos   = 1'b1;
                bundle.err   = 1'b1;
                bundle.count = 2'd1;
            end else if (bundle.count == 2'd0) begin
                bundle.count = 2'd1;
            end
            lc_next = 2'd0;
        end
    end

    assign push = in_fire && (bundle.count != 2'd0);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            lc_reg    <= 2'd0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            lc_reg    <= lc_next;
        end
    end

    // Window and captured escape bytes
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            lb0_reg  <= lb0_next;
            lb1_reg  <= lb1_next;
            fill_reg <= fill_next;
            ch_reg   <= ch_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/emrle_queue.sv */
`default_nettype none
module emrle_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire emrle_pkg::bundle_t  push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     not_empty,
    output emrle_pkg::bundle_t       pop_data
);
    import emrle_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bundle_t          entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed transaction
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

/* rtl/emrle_back.sv */
`default_nettype none
module emrle_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_not_empty,
    input  wire emrle_pkg::bundle_t  q_data,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [23:0]              m_tdata,
    output logic                     m_tlast,
    output logic [1:0]               m_tuser
);
    import emrle_pkg::*;

    bundle_t     bundle_reg;
    logic        valid_reg;
    logic [1:0]  idx_reg;
    logic        last_res;
    logic        m_fire;

    assign last_res = (idx_reg == 2'(bundle_reg.count - 2'd1));
    assign m_fire   = valid_reg && m_tready;
    // Load the next bundle when empty or the final result goes out
    assign q_pop    = q_not_empty && (!valid_reg || (m_fire && last_res));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (m_fire) begin
            if (last_res) valid_reg <= 1'b0;
            else          idx_reg   <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) bundle_reg <= q_data;
    end

    // Present the selected result
    assign m_tvalid = valid_reg;
    assign m_tdata  = {bundle_reg.length[idx_reg], bundle_reg.value[idx_reg]};
    assign m_tlast  = bundle_reg.eos && last_res;
    assign m_tuser  = {bundle_reg.err, last_res};

endmodule
`default_nettype wire

/* rtl/escape_marker_rle_decoder_top.sv */
// Escape-marker RLE decoder: one compressed byte accepted per cycle while the queue is not full.
// A byte's results are written into the queue, then loaded into the output register.
// An end-of-stream byte may give up to three results; the single-result output register
// presents them one at a time.
// Reset: aresetn synchronous active low; clears escape phase, window and queue.
`default_nettype none
`include "escape_marker_rle_decoder_top_macros.svh"
module escape_marker_rle_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tlast,   // end_of_stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,   // [7:0] run_value, [23:8] run_length
    output logic              m_tlast,   // stream_done
    output logic [1:0]        m_tuser    // [0] last_of_item, [1] truncated_error
);
    import emrle_pkg::*;

    logic     s_fire;
    logic     push;
    logic     q_full;
    logic     q_not_empty;
    logic     q_pop;
    bundle_t  push_data;
    bundle_t  pop_data;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;

    emrle_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_byte (s_tdata),
        .in_eos  (s_tlast),
        .push    (push),
        .bundle  (push_data)
    );

    emrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    emrle_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // A truncation result is the lone, empty, final result of its stream
    `EMRLE_ASSERT_IMPL(a_err_is_final, m_tvalid && m_tuser[1],
        m_tlast && m_tuser[0] && (m_tdata[23:8] == 16'd0),
        "truncation result malformed")
    // End of stream is always the last result of its byte
    `EMRLE_ASSERT_IMPL(a_done_is_last, m_tvalid && m_tlast, m_tuser[0],
        "stream_done without last_of_item")
    // A zero-length result only marks the end of a stream
    `EMRLE_ASSERT_IMPL(a_zero_len_end, m_tvalid && (m_tdata[23:8] == 16'd0), m_tlast,
        "zero length before end of stream")

endmodule
`default_nettype wire

/* sim/emrle_run_checker.sv */
module emrle_run_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_stream
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // [7:0] run_value, [23:8] run_length
    input  wire logic        m_tlast,   // stream_done
    input  wire logic [1:0]  m_tuser,   // [0] last_of_item, [1] truncated_error
    output int unsigned      fail_count,
    output int unsigned      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import emrle_pkg::*;

    typedef struct packed {
        logic [7:0]  value;
        logic [15:0] length;
        logic        last_of_item;
        logic        stream_done;
        logic        trunc_err;
    } run_rec_t;

    // Decoder state as the predictor sees it
    logic [7:0] window [2];
    int         window_cnt;
    phase_t     esc_phase;
    logic [7:0] fill_byte;
    logic [7:0] count_hi;

    run_rec_t   expected_runs [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic run_rec_t make_run(logic [7:0] value, logic [15:0] length,
                                          logic trunc);
        run_rec_t rec;
        rec.value        = value;
        rec.length       = length;
        rec.last_of_item = 1'b0;
        rec.stream_done  = 1'b0;
        rec.trunc_err    = trunc;
        return rec;
    endfunction

    task automatic clear_decoder();
        window[0]  = 8'h00;
        window[1]  = 8'h00;
        window_cnt = 0;
        esc_phase  = PH_IDLE;
        fill_byte  = 8'h00;
        count_hi   = 8'h00;
    endtask

    // Work out the runs one compressed byte gives and queue them
    task automatic decode_byte(logic [7:0] x, logic eos);
        run_rec_t    recs [3];
        int          n;
        int          i;
        logic        cut;
        logic [15:0] len;
        n   = 0;
        cut = 1'b0;
        case (esc_phase)
            PH_FILL: begin
                fill_byte = x;
                esc_phase = PH_CNT_HI;
                cut       = eos;
            end
            PH_CNT_HI: begin
                count_hi  = x;
                esc_phase = PH_CNT_LO;
                cut       = eos;
            end
            PH_CNT_LO: begin
                len       = {count_hi, x};
                esc_phase = PH_IDLE;
                // a zero count gives no run
                if (len != 16'h0000) begin
                    recs[n] = make_run(fill_byte, len, 1'b0);
                    n++;
                end
            end
            default: begin
                if (window_cnt == 2 && window[0] == MARK_A && window[1] == MARK_B &&
                    x == MARK_C) begin
                    window_cnt = 0;
                    esc_phase  = PH_FILL;
                    cut        = eos;
                end else if (window_cnt == 2) begin
                    recs[n] = make_run(window[0], 16'h0001, 1'b0);
                    n++;
                    window[0] = window[1];
                    window[1] = x;
                end else begin
                    window[window_cnt] = x;
                    window_cnt++;
                end
                // flush pending window bytes as literals at end of stream
                if (eos && !cut) begin
                    for (i = 0; i < window_cnt; i++) begin
                        recs[n] = make_run(window[i], 16'h0001, 1'b0);
                        n++;
                    end
                end
            end
        endcase
        if (eos) begin
            if (cut) begin
                recs[0] = make_run(8'h00, 16'h0000, 1'b1);
                n = 1;
            end else if (n == 0) begin
                recs[0] = make_run(8'h00, 16'h0000, 1'b0);
                n = 1;
            end
            recs[n-1].stream_done = 1'b1;
            clear_decoder();
        end
        if (n > 0)
            recs[n-1].last_of_item = 1'b1;
        for (i = 0; i < n; i++)
            expected_runs.push_back(recs[i]);
    endtask

    task automatic note_failure(run_rec_t want, run_rec_t got, logic have_want);
        if (fail_count < 10) begin
            if (have_want)
                $display("run check failed: expected val %02h len %04h last %0b done %0b err %0b, got val %02h len %04h last %0b done %0b err %0b",
                         want.value, want.length, want.last_of_item, want.stream_done,
                         want.trunc_err, got.value, got.length, got.last_of_item,
                         got.stream_done, got.trunc_err);
            else
                $display("run check failed: unexpected val %02h len %04h last %0b done %0b err %0b",
                         got.value, got.length, got.last_of_item, got.stream_done,
                         got.trunc_err);
        end
        fail_count++;
    endtask

    // Predict on each input transaction, compare on each result transaction
    always @(posedge aclk) begin : watch
        run_rec_t got;
        run_rec_t want;
        if (!aresetn) begin
            clear_decoder();
            expected_runs.delete();
        end else begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.value        = m_tdata[7:0];
                got.length       = m_tdata[23:8];
                got.last_of_item = m_tuser[0];
                got.stream_done  = m_tlast;
                got.trunc_err    = m_tuser[1];
                if (expected_runs.size() == 0) begin
                    want = '0;
                    note_failure(want, got, 1'b0);
                end else begin
                    want = expected_runs.pop_front();
                    if (got.value !== want.value || got.length !== want.length ||
                        got.last_of_item !== want.last_of_item ||
                        got.stream_done !== want.stream_done ||
                        got.trunc_err !== want.trunc_err)
                        note_failure(want, got, 1'b1);
                end
            end
        end
        pending = expected_runs.size();
    end

endmodule

/* sim/escape_marker_rle_decoder_top_tb.sv */
module escape_marker_rle_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] MK_A = 8'hCB;
    localparam logic [7:0] MK_B = 8'hED;
    localparam logic [7:0] MK_C = 8'h37;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int unsigned fail_count;
    int unsigned pending;

    int          send_idle = 23;
    int          recv_idle = 63;
    int          bytes_sent = 0;
    logic [7:0]  stream_q [$];

    escape_marker_rle_decoder_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    emrle_run_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Offer one byte, idling first at random, and hold it until the transaction
    task automatic send_byte(logic [7:0] d, logic eos);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // Send the queued stream, marking its final byte
    task automatic send_stream();
        int i;
        for (i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    // Build a stream: mostly literals and full escapes, some broken markers
    task automatic build_stream();
        int          tokens;
        int          t;
        int          r;
        int          c;
        logic [7:0]  b;
        logic [15:0] cnt;
        tokens = $urandom_range(1, 6);
        for (t = 0; t < tokens; t++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                b = 8'($urandom_range(255));
                c = $urandom_range(9);
                if (c == 0)
                    b = MK_A;
                else if (c == 1)
                    b = MK_B;
                else if (c == 2)
                    b = MK_C;
                stream_q.push_back(b);
            end else if (r < 80) begin
                c = $urandom_range(9);
                if (c == 0)
                    cnt = 16'h0000;
                else if (c == 1)
                    cnt = 16'hFFFF;
                else if (c < 5)
                    cnt = 16'($urandom_range(65535));
                else
                    cnt = 16'($urandom_range(1, 300));
                stream_q.push_back(MK_A);
                stream_q.push_back(MK_B);
                stream_q.push_back(MK_C);
                stream_q.push_back(8'($urandom_range(255)));
                stream_q.push_back(cnt[15:8]);
                stream_q.push_back(cnt[7:0]);
            end else if (r < 92) begin
                // broken marker
                stream_q.push_back(MK_A);
                if ($urandom_range(1))
                    stream_q.push_back(MK_B);
                stream_q.push_back(8'($urandom_range(255)));
            end else begin
                stream_q.push_back(8'($urandom_range(255)));
            end
        end
        // cut some streams off inside an escape
        if ($urandom_range(99) < 15) begin
            stream_q.push_back(MK_A);
            stream_q.push_back(MK_B);
            stream_q.push_back(MK_C);
            c = $urandom_range(2);
            for (t = 0; t < c; t++)
                stream_q.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic queue_bytes(input logic [7:0] bytes [$]);
        int i;
        for (i = 0; i < bytes.size(); i++)
            stream_q.push_back(bytes[i]);
    endtask

    initial begin : stimulus
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Literal extremes, longest run, zero count escape closing the stream
        queue_bytes('{8'h00, 8'hFF, MK_A, MK_B, MK_C, 8'hAA, 8'hFF, 8'hFF,
                      MK_A, MK_B, MK_C, 8'h11, 8'h00, 8'h00});
        send_stream();
        // Partial marker at the end
        queue_bytes('{MK_A, MK_B});
        send_stream();
        // Escape cut off right on the marker
        queue_bytes('{MK_A, MK_B, MK_C});
        send_stream();
        // Full window flushed at the end: three runs from one byte
        queue_bytes('{8'h12, 8'h34, 8'h56});
        send_stream();
        // Escape cut off after the fill value
        queue_bytes('{MK_A, MK_B, MK_C, 8'h42});
        send_stream();

        // Random streams under three idling mixes
        while (bytes_sent < 127) begin
            build_stream();
            send_stream();
        end
        send_idle = 63;
        recv_idle = 23;
        while (bytes_sent < 254) begin
            build_stream();
            send_stream();
        end
        send_idle = 0;
        recv_idle = 0;
        while (bytes_sent < 380) begin
            build_stream();
            send_stream();
        end
        s_tvalid <= 1'b0;

        // Drain outstanding runs, then let the output register settle
        k = 0;
        @(negedge aclk);
        while (pending != 0 && k < 20000) begin
            @(negedge aclk);
            k++;
        end
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
